[sv/kls_pkg.sv]
// ----------------------------------------------------------------------------
// kls_pkg
// Shared types and opcodes for the keyboard layer stack.
// ----------------------------------------------------------------------------
package kls_pkg;

  localparam int LAYER_W = 4;
  localparam int OPCODE_W = 2;
  localparam int CFG_W = 5;
  localparam int DEPTH_OUT_W = 4;

  localparam logic [OPCODE_W-1:0] OP_ACTIVATE   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DEACTIVATE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_TOGGLE     = 2'd2;

  typedef logic [LAYER_W-1:0] layer_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic   push;
    logic   pull;
    layer_t layer;
  } cell_ctl_t;

  // Running results handed from each cell to the one above it.
  typedef struct packed {
    logic   found;
    logic   rm_top;
    layer_t top;
    layer_t second;
  } chain_t;

endpackage

[sv/kls_cell.sv]
// ----------------------------------------------------------------------------
// kls_cell
// One stack slot: holds a layer, compares it and passes chain results upward.
// ----------------------------------------------------------------------------
module kls_cell #(
  parameter int CNT_W = 4,
  parameter int IDX   = 0
) (
  input  logic                clk,
  input  kls_pkg::cell_ctl_t  ctl,
  input  logic [CNT_W-1:0]    count,
  input  kls_pkg::chain_t     chain_in,
  input  kls_pkg::layer_t     up_slot,
  output kls_pkg::layer_t     slot,
  output kls_pkg::chain_t     chain_out
);
  import kls_pkg::*;

  layer_t slot_r;
  layer_t slot_nxt;
  logic   occ;
  logic   is_top;
  logic   is_second;
  logic   is_free;
  logic   match;

  assign occ       = (32'(count) > IDX);
  assign is_top    = (32'(count) == IDX + 1);
  assign is_second = (32'(count) == IDX + 2);
  assign is_free   = (32'(count) == IDX);
  assign match     = occ && (slot_r == ctl.layer);

  always_comb begin
    chain_out.found  = chain_in.found | match;
    chain_out.rm_top = chain_in.rm_top | (is_top & match & ~chain_in.found);
    chain_out.top    = is_top ? slot_r : chain_in.top;
    chain_out.second = is_second ? slot_r : chain_in.second;
  end

  // Load on push into the first free slot; shift down from the removal point.
  always_comb begin
    slot_nxt = slot_r;
    if (ctl.push && is_free) begin
      slot_nxt = ctl.layer;
    end else if (ctl.pull && chain_out.found) begin
      slot_nxt = up_slot;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot = slot_r;

endmodule

[sv/keyboard_layer_stack_top.sv]
// ----------------------------------------------------------------------------
// keyboard_layer_stack_top
// Ordered stack of active keyboard layers built as a row of slot cells.
// ----------------------------------------------------------------------------
// Each transfer on the input channel carries an opcode (activate, deactivate,
// toggle) and a layer; each produces exactly one result transfer with the new
// top layer (0 when the stack is empty), the depth and a changed flag. An item
// is first captured into registers; then every cell compares its slot against
// the layer and the found/top chain ripples up the row of cells, after which
// the stack commits and the result lands in the output register. The
// next item is taken once the current one has been committed; a held result
// only stalls the commit. cfg_we writes defined_layers (reset 1); write it only
// while no item is in flight. The stack needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module keyboard_layer_stack_top #(
  parameter int STACK_DEPTH = 8,
  parameter int MAX_LAYERS  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [kls_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [kls_pkg::OPCODE_W-1:0]    in_opcode,
  input  logic [kls_pkg::LAYER_W-1:0]     in_layer,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kls_pkg::LAYER_W-1:0]     out_top_layer,
  output logic [kls_pkg::DEPTH_OUT_W-1:0] out_depth,
  output logic                            out_changed
);
  import kls_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  // Configuration
  logic [CFG_W-1:0] defined_r;

  // Captured item
  logic                busy_r;
  logic [OPCODE_W-1:0] op_r;
  layer_t              lay_r;

  // Stack fill level
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // Result register
  logic       out_valid_r;
  layer_t     out_top_r;
  logic [DEPTH_OUT_W-1:0] out_depth_r;
  logic       out_changed_r;

  // Cell row
  chain_t    chain [STACK_DEPTH+1];
  layer_t    slots [STACK_DEPTH];
  cell_ctl_t ctl;

  logic   fire;
  logic   present;
  logic   try_push;
  logic   try_pull;
  logic   over_limit;
  logic   full;
  logic   push_ok;
  logic   pull_ok;
  layer_t new_top;

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      defined_r <= CFG_W'(1);
    end else if (cfg_we) begin
      defined_r <= cfg_wdata;
    end
  end

  // Capture the item; hold it until the commit fires
  assign in_ready = ~busy_r;
  assign fire     = busy_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      busy_r <= 1'b1;
    end else if (fire) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= in_opcode;
      lay_r <= in_layer;
    end
  end

  // Chain starts empty: nothing found, top and next-to-top read as layer 0
  assign chain[0] = '0;

  generate
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      layer_t up;
      if (i == STACK_DEPTH - 1) begin : g_last
        assign up = slots[i];
      end else begin : g_mid
        assign up = slots[i+1];
      end
      kls_cell #(
        .CNT_W (CNT_W),
        .IDX   (i)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .count     (count_r),
        .chain_in  (chain[i]),
        .up_slot   (up),
        .slot      (slots[i]),
        .chain_out (chain[i+1])
      );
    end
  endgenerate

  // Decide the operation from the chain results
  assign present = chain[STACK_DEPTH].found;

  always_comb begin
    try_push = 1'b0;
    try_pull = 1'b0;
    case (op_r)
      OP_ACTIVATE: begin
        try_push = 1'b1;
      end
      OP_DEACTIVATE: begin
        try_pull = 1'b1;
      end
      OP_TOGGLE: begin
        try_pull = present;
        try_push = ~present;
      end
      default: begin
        try_push = 1'b0;
        try_pull = 1'b0;
      end
    endcase
  end

  // Limit is min(defined_layers, MAX_LAYERS)
  assign over_limit = ({1'b0, lay_r} >= defined_r) || (32'(lay_r) >= MAX_LAYERS);
  assign full       = (32'(count_r) >= STACK_DEPTH);
  assign push_ok    = try_push && !over_limit && !full && (lay_r != chain[STACK_DEPTH].top);
  assign pull_ok    = try_pull && present;

  always_comb begin
    ctl.push  = fire && push_ok;
    ctl.pull  = fire && pull_ok;
    ctl.layer = lay_r;
  end

  // New fill level and top after the commit
  always_comb begin
    count_nxt = count_r;
    new_top   = chain[STACK_DEPTH].top;
    if (push_ok) begin
      count_nxt = count_r + CNT_W'(1);
      new_top   = lay_r;
    end else if (pull_ok) begin
      count_nxt = count_r - CNT_W'(1);
      if (chain[STACK_DEPTH].rm_top) begin
        new_top = chain[STACK_DEPTH].second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (fire) begin
      count_r <= count_nxt;
    end
  end

  // Output register: load on commit, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_top_r     <= new_top;
      out_depth_r   <= DEPTH_OUT_W'(count_nxt);
      out_changed_r <= push_ok | pull_ok;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_top_layer = out_top_r;
  assign out_depth     = out_depth_r;
  assign out_changed   = out_changed_r;

endmodule
